// ----- rtl/core/utclt_pkg.sv -----
package utclt_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STD_OFFSET  = 2'd0,
    REG_DST_OFFSET  = 2'd1,
    REG_DST_ENABLED = 2'd2
  } cfg_index_t;

  localparam int CFG_W = 18;
  localparam int TIME_W = 32;

  // Register stages inside the civil conversion unit
  localparam int CIV_LAT = 8;

  // Calendar constants
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
  localparam logic [19:0] ERA4_START    = 20'd584388;
  localparam logic [19:0] ERA5_START    = 20'd730485;
  localparam logic [11:0] ERA4_YEAR     = 12'd1600;
  localparam logic [11:0] ERA5_YEAR     = 12'd2000;
  localparam logic [17:0] DOE_CENT1     = 18'd36524;
  localparam logic [17:0] DOE_CENT2     = 18'd73048;
  localparam logic [17:0] DOE_CENT3     = 18'd109572;
  localparam logic [17:0] DOE_LAST      = 18'd146096;
  localparam logic [15:0] EPOCH_WDAY    = 16'd4;

  // Reciprocals, exact for the full input range of each stage
  localparam logic [25:0] RCP_DAY   = 26'd50903317;  // /675 of t>>7, shift 35
  localparam logic [16:0] RCP_WEEK  = 17'd74899;     // /7, shift 19
  localparam logic [13:0] RCP_HOUR  = 14'd9321;      // /225 of tod>>4, shift 21
  localparam logic [16:0] RCP_1460  = 17'd91930;     // /365 of doe>>2, shift 25
  localparam logic [18:0] RCP_YEAR  = 19'd367720;    // /365, shift 27
  localparam logic [10:0] RCP_MIN   = 11'd1093;      // /15 of rem>>2, shift 14
  localparam logic [11:0] RCP_MONTH = 12'd3427;      // /153, shift 19

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  // First day of a March-based month, counted from March 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/utclt_civil.sv -----
module utclt_civil (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [31:0]            t,
  output utclt_pkg::civil_t      civ,
  output logic [2:0]             wday
);
  import utclt_pkg::*;

  // stage 1
  logic [50:0] p_day;
  logic [15:0] s1_days;
  logic [31:0] s1_t;

  // stage 2
  logic [32:0] p_tod;
  logic [19:0] z;
  logic [15:0] wx;
  logic [32:0] p_wk;
  logic [16:0] s2_tod;
  logic [19:0] s2_z;
  logic        s2_era5;
  logic [15:0] s2_wx;
  logic [13:0] s2_wq;

  // stage 3
  logic [19:0] doe_full;
  logic [16:0] wq7;
  logic [16:0] wdiff;
  logic [26:0] p_hr;
  logic [17:0] s3_doe;
  logic        s3_era5;
  logic [2:0]  s3_wday;
  logic [16:0] s3_tod;
  logic [4:0]  s3_hour;

  // stage 4
  logic [32:0] p_a;
  logic [2:0]  cent;
  logic [17:0] n;
  logic [16:0] hr_sec;
  logic [16:0] rem_full;
  logic [17:0] s4_n;
  logic [17:0] s4_doe;
  logic        s4_era5;
  logic [2:0]  s4_wday;
  logic [4:0]  s4_hour;
  logic [11:0] s4_rem;

  // stage 5
  logic [36:0] p_y;
  logic [20:0] p_min;
  logic [8:0]  s5_yoe;
  logic [17:0] s5_doe;
  logic        s5_era5;
  logic [2:0]  s5_wday;
  logic [4:0]  s5_hour;
  logic [11:0] s5_rem;
  logic [5:0]  s5_minute;

  // stage 6
  logic [17:0] y365;
  logic [1:0]  yc;
  logic [17:0] ystart;
  logic [17:0] doy_full;
  logic [11:0] min_sec;
  logic [11:0] sec_full;
  logic [8:0]  s6_doy;
  logic [8:0]  s6_yoe;
  logic        s6_era5;
  logic [2:0]  s6_wday;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_minute;
  logic [5:0]  s6_second;

  // stage 7
  logic [10:0] mv;
  logic [22:0] p_m;
  logic [3:0]  s7_mp;
  logic [8:0]  s7_doy;
  logic [8:0]  s7_yoe;
  logic        s7_era5;
  logic [2:0]  s7_wday;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_minute;
  logic [5:0]  s7_second;

  // stage 8
  logic [8:0]  day_full;
  logic [3:0]  month_c;
  logic [11:0] year_c;

  always_comb begin
    // day count from seconds
    p_day = {26'b0, t[31:7]} * {25'b0, RCP_DAY};

    // time of day, era, weekday quotient
    p_tod = {17'b0, s1_days} * {16'b0, SEC_PER_DAY};
    z     = {4'b0, s1_days} + DAYS_TO_EPOCH;
    wx    = s1_days + EPOCH_WDAY;
    p_wk  = {17'b0, wx} * {16'b0, RCP_WEEK};

    // day of era, weekday, hour
    doe_full = s2_z - (s2_era5 ? ERA5_START : ERA4_START);
    wq7      = {s2_wq, 3'b0} - {3'b0, s2_wq};
    wdiff    = {1'b0, s2_wx} - wq7;
    p_hr     = {14'b0, s2_tod[16:4]} * {13'b0, RCP_HOUR};

    // leap correction numerator, seconds within the hour
    p_a  = {17'b0, s3_doe[17:2]} * {16'b0, RCP_1460};
    cent = 3'(s3_doe >= DOE_CENT1) + 3'(s3_doe >= DOE_CENT2)
         + 3'(s3_doe >= DOE_CENT3) + 3'(s3_doe >= DOE_LAST);
    n    = s3_doe - {11'b0, p_a[31:25]} + {15'b0, cent}
         - {17'b0, (s3_doe >= DOE_LAST)};
    hr_sec   = {12'b0, s3_hour} * {5'b0, SEC_PER_HOUR};
    rem_full = s3_tod - hr_sec;

    // year of era, minute
    p_y   = {19'b0, s4_n} * {18'b0, RCP_YEAR};
    p_min = {11'b0, s4_rem[11:2]} * {10'b0, RCP_MIN};

    // day of year, second
    y365     = {9'b0, s5_yoe} * 18'd365;
    yc       = 2'(s5_yoe >= 9'd100) + 2'(s5_yoe >= 9'd200) + 2'(s5_yoe >= 9'd300);
    ystart   = y365 + {11'b0, s5_yoe[8:2]} - {16'b0, yc};
    doy_full = s5_doe - ystart;
    min_sec  = {s5_minute, 6'b0} - {4'b0, s5_minute, 2'b0};
    sec_full = s5_rem - min_sec;

    // March-based month
    mv  = {s6_doy, 2'b0} + {2'b0, s6_doy} + 11'd2;
    p_m = {12'b0, mv} * {11'b0, RCP_MONTH};

    // final calendar fields
    day_full = s7_doy - month_start(s7_mp) + 9'd1;
    month_c  = (s7_mp < 4'd10) ? (s7_mp + 4'd3) : (s7_mp - 4'd9);
    year_c   = (s7_era5 ? ERA5_YEAR : ERA4_YEAR) + {3'b0, s7_yoe}
             + {11'b0, (s7_mp >= 4'd10)};
  end

  // advance every stage together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_days <= p_day[50:35];
      s1_t    <= t;

      s2_tod  <= 17'(s1_t - p_tod[31:0]);
      s2_z    <= z;
      s2_era5 <= (z >= ERA5_START);
      s2_wx   <= wx;
      s2_wq   <= p_wk[32:19];

      s3_doe  <= doe_full[17:0];
      s3_era5 <= s2_era5;
      s3_wday <= wdiff[2:0];
      s3_tod  <= s2_tod;
      s3_hour <= p_hr[25:21];

      s4_n    <= n;
      s4_doe  <= s3_doe;
      s4_era5 <= s3_era5;
      s4_wday <= s3_wday;
      s4_hour <= s3_hour;
      s4_rem  <= rem_full[11:0];

      s5_yoe    <= p_y[35:27];
      s5_doe    <= s4_doe;
      s5_era5   <= s4_era5;
      s5_wday   <= s4_wday;
      s5_hour   <= s4_hour;
      s5_rem    <= s4_rem;
      s5_minute <= p_min[19:14];

      s6_doy    <= doy_full[8:0];
      s6_yoe    <= s5_yoe;
      s6_era5   <= s5_era5;
      s6_wday   <= s5_wday;
      s6_hour   <= s5_hour;
      s6_minute <= s5_minute;
      s6_second <= sec_full[5:0];

      s7_mp     <= p_m[22:19];
      s7_doy    <= s6_doy;
      s7_yoe    <= s6_yoe;
      s7_era5   <= s6_era5;
      s7_wday   <= s6_wday;
      s7_hour   <= s6_hour;
      s7_minute <= s6_minute;
      s7_second <= s6_second;

      civ.year   <= year_c;
      civ.month  <= month_c;
      civ.day    <= day_full[4:0];
      civ.hour   <= s7_hour;
      civ.minute <= s7_minute;
      civ.second <= s7_second;
      wday       <= s7_wday;
    end
  end

endmodule

// ----- rtl/core/utc_to_local_civil_time.sv -----
// UTC seconds to local civil date and time, with the US daylight rule.
//
// Input channel (in_valid/in_ready): utc_seconds and clock_valid. Output
// channel (out_valid/out_ready): valid_res, year, month, day, hour, minute,
// second and in_dst. Each request produces exactly one result; a request
// with clock_valid low returns all fields zero.
// Configuration: cfg_wen/cfg_index/cfg_data write std_offset (0),
// dst_offset (1) and dst_enabled (2); other indexes are ignored. Write only
// while no request is in flight.
// From acceptance to out_valid a request passes one offset-add stage,
// the eight-stage calendar unit (reciprocal multiplies, no dividers)
// and one stage that applies the daylight rule and picks the result.
// Standard and daylight local times are converted side by side, so one
// request is accepted every cycle unless stalled. When out_valid is high
// and out_ready low the whole pipeline holds and in_ready drops; nothing
// is dropped or repeated. Reset clears offsets, enable and all valid bits.
module utc_to_local_civil_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] utc_seconds,
  input  logic        clock_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        in_dst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import utclt_pkg::*;

  logic signed [CFG_W-1:0] std_offset;
  logic signed [CFG_W-1:0] dst_offset;
  logic                    dst_enabled;

  logic              adv;
  logic [CIV_LAT:0]  vld;
  logic [CIV_LAT:0]  clk_ok;
  logic [CIV_LAT:0]  dst_en;
  logic [TIME_W-1:0] t_std;
  logic [TIME_W-1:0] t_dst;

  civil_t     civ_std;
  civil_t     civ_dst;
  logic [2:0] wday_std;

  logic       rule;
  logic       use_dst;
  civil_t     pick;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      std_offset  <= '0;
      dst_offset  <= '0;
      dst_enabled <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_STD_OFFSET:  std_offset  <= cfg_data;
        REG_DST_OFFSET:  dst_offset  <= cfg_data;
        REG_DST_ENABLED: dst_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold the whole pipeline while a result waits
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // add both offsets, wrapping at 32 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      t_std <= utc_seconds + {{(TIME_W-CFG_W){std_offset[CFG_W-1]}}, std_offset};
      t_dst <= utc_seconds + {{(TIME_W-CFG_W){dst_offset[CFG_W-1]}}, dst_offset};
    end
  end

  // valid bits and request flags travel alongside the calendar unit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[CIV_LAT-1:0], in_valid && in_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clk_ok <= {clk_ok[CIV_LAT-1:0], clock_valid};
      dst_en <= {dst_en[CIV_LAT-1:0], dst_enabled};
    end
  end

  utclt_civil u_civ_std (
    .clk  (clk),
    .adv  (adv),
    .t    (t_std),
    .civ  (civ_std),
    .wday (wday_std)
  );

  utclt_civil u_civ_dst (
    .clk  (clk),
    .adv  (adv),
    .t    (t_dst),
    .civ  (civ_dst),
    .wday ()
  );

  // US rule on standard local time: second Sunday of March to first
  // Sunday of November, switching at 02:00
  always_comb begin
    rule = 1'b0;
    if (civ_std.month > 4'd3 && civ_std.month < 4'd11) begin
      rule = 1'b1;
    end else if (civ_std.month == 4'd3) begin
      rule = ({2'b0, wday_std} + 5'd8 <= civ_std.day) &&
             !(wday_std == 3'd0 && civ_std.day <= 5'd14 && civ_std.hour < 5'd2);
    end else if (civ_std.month == 4'd11) begin
      rule = (civ_std.day <= {2'b0, wday_std}) ||
             (wday_std == 3'd0 && civ_std.day <= 5'd7 && civ_std.hour < 5'd2);
    end
    use_dst = dst_en[CIV_LAT] && rule;
    pick    = use_dst ? civ_dst : civ_std;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[CIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      valid_res <= clk_ok[CIV_LAT];
      in_dst    <= clk_ok[CIV_LAT] && use_dst;
      if (clk_ok[CIV_LAT]) begin
        year   <= pick.year;
        month  <= pick.month;
        day    <= pick.day;
        hour   <= pick.hour;
        minute <= pick.minute;
        second <= pick.second;
      end else begin
        year   <= '0;
        month  <= '0;
        day    <= '0;
        hour   <= '0;
        minute <= '0;
        second <= '0;
      end
    end
  end

  // converted results carry a legal date and time
  a_legal_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> month >= 4'd1 && month <= 4'd12 &&
                               day >= 5'd1 && year >= 12'd1969)
    else $error("converted result has an illegal date");

  a_legal_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("converted result has an illegal time of day");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> year == 12'd0 && month == 4'd0 && day == 5'd0 &&
                                hour == 5'd0 && !in_dst)
    else $error("result for an unsynchronized clock is not cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule
